// ===== src/ifps_pkg.sv =====
`timescale 1ns / 1ps

package ifps_pkg;

  // Field widths of the channel words.
  localparam int unsigned AddrW      = 13;
  localparam int unsigned WordW      = 32;
  localparam int unsigned OpW        = 2;
  localparam int unsigned WaitW      = 16;
  localparam int unsigned ShortW     = 10;
  localparam int unsigned CountW     = 6;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam int unsigned AddressBitsDef = 13;

  // Operation codes.
  localparam logic [OpW-1:0] OpErase = 2'd0;
  localparam logic [OpW-1:0] OpRead  = 2'd1;
  localparam logic [OpW-1:0] OpWrite = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgEraseWait    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEraseSettle  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWriteRecover = 2'd2;

  // Register reset values.
  localparam logic [WaitW-1:0]  EraseWaitRst    = 16'd25000;
  localparam logic [ShortW-1:0] EraseSettleRst  = 10'd150;
  localparam logic [ShortW-1:0] WriteRecoverRst = 10'd300;

  // Mode codes sent on RESETB.
  localparam logic [15:0] ModeErase = 16'h59F3;
  localparam logic [15:0] ModeRead  = 16'h6AC9;
  localparam logic [15:0] ModeWrite = 16'h62CD;

  // Bit and pulse counts.
  localparam logic [CountW-1:0] ModeBits   = 6'd16;
  localparam logic [CountW-1:0] FrameBits  = 6'd18;
  localparam logic [CountW-1:0] DataBits   = 6'd32;
  localparam logic [CountW-1:0] LoadPulses = 6'd6;
  localparam logic [CountW-1:0] ExitPulses = 6'd10;
  localparam logic [CountW-1:0] ProgSteps  = 6'd6;

  // Segment lengths in ticks.
  localparam logic [WaitW-1:0] LenBase      = 16'd3;
  localparam logic [WaitW-1:0] LenEraseSet  = 16'd7;
  localparam logic [WaitW-1:0] LenReadWait  = 16'd40;
  localparam logic [WaitW-1:0] LenLoad      = 16'd10;
  localparam logic [WaitW-1:0] LenOne       = 16'd1;

  typedef enum logic [5:0] {
    PhIdle = 6'd0,  PhMs   = 6'd1,  PhMh   = 6'd2,  PhMl   = 6'd3,
    PhAs   = 6'd4,  PhAh   = 6'd5,  PhAl   = 6'd6,  PhDs   = 6'd7,
    PhDh   = 6'd8,  PhDl   = 6'd9,  PhE1s  = 6'd10, PhE1h  = 6'd11,
    PhE1l  = 6'd12, PhE2s  = 6'd13, PhE2h  = 6'd14, PhE2l  = 6'd15,
    PhEw   = 6'd16, PhE3h  = 6'd17, PhE3l  = 6'd18, PhEs   = 6'd19,
    PhE4h  = 6'd20, PhE4l  = 6'd21, PhRw   = 6'd22, PhRlh  = 6'd23,
    PhRll  = 6'd24, PhRxl  = 6'd25, PhRxh  = 6'd26, PhWpl  = 6'd27,
    PhWph  = 6'd28, PhWfh  = 6'd29, PhWfl  = 6'd30, PhXs   = 6'd31,
    PhXh   = 6'd32, PhXl   = 6'd33, PhRec  = 6'd34
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [CountW-1:0]  bits;
  } step_t;

  typedef struct packed {
    logic [WaitW-1:0]  erase_wait;
    logic [ShortW-1:0] erase_settle;
    logic [ShortW-1:0] write_recover;
  } cfg_t;

  typedef struct packed {
    logic             start_req;
    logic [OpW-1:0]   operation;
    logic [AddrW-1:0] word_address;
    logic [WordW-1:0] write_word;
    logic             sda_sample;
  } item_t;

  typedef struct packed {
    logic             clock_pin;
    logic             data_pin;
    logic             data_drive;
    logic             reset_pin;
    logic             busy_res;
    logic             done_res;
    logic [WordW-1:0] read_word;
  } res_t;

  // Hold time of each program pulse half, walked from six steps left down to one.
  function automatic logic [3:0] prog_hold(logic [CountW-1:0] bits_left);
    logic [3:0] len;
    case (bits_left)
      6'd4:    len = 4'd6;
      6'd3:    len = 4'd12;
      default: len = 4'd3;
    endcase
    return len;
  endfunction

endpackage

// ===== src/ifps_if.sv =====
`timescale 1ns / 1ps

interface ifps_item_if;
  logic                        valid;
  logic                        ready;
  logic                        start_req;
  logic [ifps_pkg::OpW-1:0]    operation;
  logic [ifps_pkg::AddrW-1:0]  word_address;
  logic [ifps_pkg::WordW-1:0]  write_word;
  logic                        sda_sample;

  modport source (output valid, start_req, operation, word_address, write_word, sda_sample,
                  input ready);
  modport sink (input valid, start_req, operation, word_address, write_word, sda_sample,
                output ready);
endinterface

interface ifps_res_if;
  logic                        valid;
  logic                        ready;
  logic                        clock_pin;
  logic                        data_pin;
  logic                        data_drive;
  logic                        reset_pin;
  logic                        busy_res;
  logic                        done_res;
  logic [ifps_pkg::WordW-1:0]  read_word;

  modport source (output valid, clock_pin, data_pin, data_drive, reset_pin, busy_res,
                  done_res, read_word, input ready);
  modport sink (input valid, clock_pin, data_pin, data_drive, reset_pin, busy_res,
                done_res, read_word, output ready);
endinterface

interface ifps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ifps_pkg::CfgIdxW-1:0]  index;
  logic [ifps_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ifps_regs.sv =====
`timescale 1ns / 1ps

module ifps_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  ifps_cfg_if.sink            cfg_i,
  output ifps_pkg::cfg_t      cfg_o
);

  ifps_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        ifps_pkg::CfgEraseWait:    cfg_d.erase_wait    = cfg_i.data;
        ifps_pkg::CfgEraseSettle:  cfg_d.erase_settle  = cfg_i.data[ifps_pkg::ShortW-1:0];
        ifps_pkg::CfgWriteRecover: cfg_d.write_recover = cfg_i.data[ifps_pkg::ShortW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.erase_wait    <= ifps_pkg::EraseWaitRst;
      cfg_q.erase_settle  <= ifps_pkg::EraseSettleRst;
      cfg_q.write_recover <= ifps_pkg::WriteRecoverRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ifps_core.sv =====
`timescale 1ns / 1ps

module ifps_core #(
  parameter int unsigned ADDRESS_BITS = ifps_pkg::AddressBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  ifps_pkg::item_t  item_i,
  input  ifps_pkg::cfg_t   cfg_i,
  output ifps_pkg::res_t   res_o
);

  localparam int unsigned AW = ifps_pkg::AddrW;
  localparam logic [AW-1:0] AddrMask =
    (ADDRESS_BITS >= AW) ? {AW{1'b1}} : AW'((1 << ADDRESS_BITS) - 1);

  ifps_pkg::step_t                 step_q, step_d, cur;
  logic [ifps_pkg::WaitW-1:0]      wait_q, wait_d, wait_cur, wait_dec;
  logic [ifps_pkg::WordW-1:0]      shift_q, shift_d, shift_cur;
  logic [ifps_pkg::WordW-1:0]      read_q, read_d;
  logic [ifps_pkg::OpW-1:0]        op_q, op_cur;
  logic [AW-1:0]                   addr_q, addr_cur;
  logic                            start;
  logic                            done;
  ifps_pkg::step_t                 adv1, adv2;
  logic [ifps_pkg::WaitW-1:0]      len1;
  logic [15:0]                     mode_word;
  logic [4:0]                      bit_idx;
  logic [ifps_pkg::WordW-1:0]      mode_ext, frame_ext;

  // One transition of the pin sequence.
  function automatic ifps_pkg::step_t advance(ifps_pkg::step_t s, logic [1:0] op);
    ifps_pkg::step_t n;
    n = s;
    case (s.phase)
      ifps_pkg::PhMs: n.phase = ifps_pkg::PhMh;
      ifps_pkg::PhMh: n.phase = ifps_pkg::PhMl;
      ifps_pkg::PhMl: begin
        if (s.bits > 6'd1) begin
          n.bits  = s.bits - 6'd1;
          n.phase = ifps_pkg::PhMs;
        end else if (op == ifps_pkg::OpErase) begin
          n.phase = ifps_pkg::PhE1s;
        end else begin
          n.bits  = ifps_pkg::FrameBits;
          n.phase = ifps_pkg::PhAs;
        end
      end
      ifps_pkg::PhAs: n.phase = ifps_pkg::PhAh;
      ifps_pkg::PhAh: n.phase = ifps_pkg::PhAl;
      ifps_pkg::PhAl: begin
        if (s.bits > 6'd1) begin
          n.bits  = s.bits - 6'd1;
          n.phase = ifps_pkg::PhAs;
        end else if (op == ifps_pkg::OpRead) begin
          n.phase = ifps_pkg::PhRw;
        end else begin
          n.bits  = ifps_pkg::DataBits;
          n.phase = ifps_pkg::PhDs;
        end
      end
      ifps_pkg::PhDs: n.phase = ifps_pkg::PhDh;
      ifps_pkg::PhDh: n.phase = ifps_pkg::PhDl;
      ifps_pkg::PhDl: begin
        if (s.bits > 6'd1) begin
          n.bits  = s.bits - 6'd1;
          n.phase = ifps_pkg::PhDs;
        end else begin
          n.bits  = ifps_pkg::ProgSteps;
          n.phase = ifps_pkg::PhWpl;
        end
      end
      ifps_pkg::PhE1s: n.phase = ifps_pkg::PhE1h;
      ifps_pkg::PhE1h: n.phase = ifps_pkg::PhE1l;
      ifps_pkg::PhE1l: n.phase = ifps_pkg::PhE2s;
      ifps_pkg::PhE2s: n.phase = ifps_pkg::PhE2h;
      ifps_pkg::PhE2h: n.phase = ifps_pkg::PhE2l;
      ifps_pkg::PhE2l: n.phase = ifps_pkg::PhEw;
      ifps_pkg::PhEw:  n.phase = ifps_pkg::PhE3h;
      ifps_pkg::PhE3h: n.phase = ifps_pkg::PhE3l;
      ifps_pkg::PhE3l: n.phase = ifps_pkg::PhEs;
      ifps_pkg::PhEs:  n.phase = ifps_pkg::PhE4h;
      ifps_pkg::PhE4h: n.phase = ifps_pkg::PhE4l;
      ifps_pkg::PhE4l: n.phase = ifps_pkg::PhXs;
      ifps_pkg::PhRw: begin
        n.bits  = ifps_pkg::LoadPulses;
        n.phase = ifps_pkg::PhRlh;
      end
      ifps_pkg::PhRlh: n.phase = ifps_pkg::PhRll;
      ifps_pkg::PhRll: begin
        if (s.bits > 6'd1) begin
          n.bits  = s.bits - 6'd1;
          n.phase = ifps_pkg::PhRlh;
        end else begin
          n.bits  = ifps_pkg::DataBits;
          n.phase = ifps_pkg::PhRxl;
        end
      end
      ifps_pkg::PhRxl: n.phase = ifps_pkg::PhRxh;
      ifps_pkg::PhRxh: begin
        if (s.bits > 6'd1) begin
          n.bits  = s.bits - 6'd1;
          n.phase = ifps_pkg::PhRxl;
        end else begin
          n.phase = ifps_pkg::PhXs;
        end
      end
      ifps_pkg::PhWpl: n.phase = ifps_pkg::PhWph;
      ifps_pkg::PhWph: begin
        if (s.bits > 6'd1) begin
          n.bits  = s.bits - 6'd1;
          n.phase = ifps_pkg::PhWpl;
        end else begin
          n.phase = ifps_pkg::PhWfh;
        end
      end
      ifps_pkg::PhWfh: n.phase = ifps_pkg::PhWfl;
      ifps_pkg::PhWfl: n.phase = ifps_pkg::PhXs;
      ifps_pkg::PhXs: begin
        n.bits  = ifps_pkg::ExitPulses;
        n.phase = ifps_pkg::PhXh;
      end
      ifps_pkg::PhXh: n.phase = ifps_pkg::PhXl;
      ifps_pkg::PhXl: begin
        if (s.bits > 6'd1) begin
          n.bits  = s.bits - 6'd1;
          n.phase = ifps_pkg::PhXh;
        end else if (op == ifps_pkg::OpWrite) begin
          n.phase = ifps_pkg::PhRec;
        end else begin
          n.phase = ifps_pkg::PhIdle;
        end
      end
      default: n.phase = ifps_pkg::PhIdle;
    endcase
    return n;
  endfunction

  // Length in ticks of the segment that a phase starts.
  function automatic logic [15:0] seg_len(ifps_pkg::step_t s, ifps_pkg::cfg_t c);
    logic [15:0] len;
    case (s.phase)
      ifps_pkg::PhE1s, ifps_pkg::PhE2s: len = ifps_pkg::LenEraseSet;
      ifps_pkg::PhEw:  len = c.erase_wait;
      ifps_pkg::PhEs:  len = 16'(c.erase_settle);
      ifps_pkg::PhRw:  len = ifps_pkg::LenReadWait;
      ifps_pkg::PhRlh, ifps_pkg::PhRll: len = ifps_pkg::LenLoad;
      ifps_pkg::PhRxl, ifps_pkg::PhRxh, ifps_pkg::PhWfh, ifps_pkg::PhWfl:
        len = ifps_pkg::LenOne;
      ifps_pkg::PhWpl, ifps_pkg::PhWph: len = 16'(ifps_pkg::prog_hold(s.bits));
      ifps_pkg::PhRec: len = 16'(c.write_recover);
      ifps_pkg::PhIdle: len = 16'd0;
      default: len = ifps_pkg::LenBase;
    endcase
    return len;
  endfunction

  // A start taken while idle makes this tick the first tick of the sequence.
  always_comb begin
    start = (step_q.phase == ifps_pkg::PhIdle) && item_i.start_req &&
            (item_i.operation inside {ifps_pkg::OpErase, ifps_pkg::OpRead,
                                      ifps_pkg::OpWrite});
    if (start) begin
      cur.phase = ifps_pkg::PhMs;
      cur.bits  = ifps_pkg::ModeBits;
      wait_cur  = ifps_pkg::LenBase;
      op_cur    = item_i.operation;
      addr_cur  = item_i.word_address & AddrMask;
      shift_cur = (item_i.operation == ifps_pkg::OpWrite) ? item_i.write_word : '0;
    end else begin
      cur       = step_q;
      wait_cur  = wait_q;
      op_cur    = op_q;
      addr_cur  = addr_q;
      shift_cur = shift_q;
    end
  end

  // Next state.
  always_comb begin
    shift_d = shift_cur;
    read_d  = read_q;
    if (cur.phase == ifps_pkg::PhRxh) begin
      shift_d = {shift_cur[ifps_pkg::WordW-2:0], item_i.sda_sample};
      if (cur.bits == 6'd1) begin
        read_d = shift_d;
      end
    end

    wait_dec = (wait_cur != '0) ? wait_cur - 16'd1 : '0;
    adv1     = advance(cur, op_cur);
    len1     = seg_len(adv1, cfg_i);
    // Only the long waits and the write recovery can be zero; the long waits are
    // followed by a segment that is never empty and the recovery by idle, so one extra hop suffices.
    adv2     = advance(adv1, op_cur);

    step_d = cur;
    wait_d = wait_cur;
    done   = 1'b0;
    if (cur.phase != ifps_pkg::PhIdle) begin
      wait_d = wait_dec;
      if (wait_dec == '0) begin
        if (len1 == '0 && adv1.phase != ifps_pkg::PhIdle) begin
          step_d = adv2;
          wait_d = seg_len(adv2, cfg_i);
        end else begin
          step_d = adv1;
          wait_d = len1;
        end
        done = (step_d.phase == ifps_pkg::PhIdle);
      end
    end
  end

  // Pin levels for this tick.
  always_comb begin
    case (op_cur)
      ifps_pkg::OpErase: mode_word = ifps_pkg::ModeErase;
      ifps_pkg::OpRead:  mode_word = ifps_pkg::ModeRead;
      default:           mode_word = ifps_pkg::ModeWrite;
    endcase
    bit_idx   = 5'(cur.bits - 6'd1);
    mode_ext  = 32'(mode_word);
    frame_ext = 32'({addr_cur, 1'b0});

    res_o            = '0;
    res_o.read_word  = read_d;
    res_o.done_res   = done;
    if (cur.phase != ifps_pkg::PhIdle) begin
      res_o.busy_res   = 1'b1;
      res_o.data_drive = 1'b1;
      case (cur.phase)
        ifps_pkg::PhMh, ifps_pkg::PhAh, ifps_pkg::PhDh, ifps_pkg::PhE1h,
        ifps_pkg::PhE2h, ifps_pkg::PhE3h, ifps_pkg::PhE4h, ifps_pkg::PhRlh,
        ifps_pkg::PhRxh, ifps_pkg::PhWph, ifps_pkg::PhWfh, ifps_pkg::PhXh:
          res_o.clock_pin = 1'b1;
        ifps_pkg::PhXs:
          res_o.clock_pin = (op_cur == ifps_pkg::OpRead);
        default: res_o.clock_pin = 1'b0;
      endcase
      case (cur.phase)
        ifps_pkg::PhMs, ifps_pkg::PhMh, ifps_pkg::PhMl: begin
          res_o.reset_pin = mode_ext[bit_idx];
          res_o.data_pin  = 1'b1;
        end
        ifps_pkg::PhAs, ifps_pkg::PhAh, ifps_pkg::PhAl:
          res_o.data_pin = frame_ext[bit_idx];
        ifps_pkg::PhDs, ifps_pkg::PhDh, ifps_pkg::PhDl:
          res_o.data_pin = shift_cur[bit_idx];
        ifps_pkg::PhE1s, ifps_pkg::PhE1h, ifps_pkg::PhE1l, ifps_pkg::PhE2s,
        ifps_pkg::PhE2h, ifps_pkg::PhE2l, ifps_pkg::PhEw, ifps_pkg::PhE3h,
        ifps_pkg::PhE3l, ifps_pkg::PhEs, ifps_pkg::PhE4h, ifps_pkg::PhE4l,
        ifps_pkg::PhWpl, ifps_pkg::PhWph, ifps_pkg::PhWfh, ifps_pkg::PhWfl:
          res_o.data_pin = 1'b1;
        ifps_pkg::PhRxl, ifps_pkg::PhRxh:
          res_o.data_drive = 1'b0;
        default: res_o.data_pin = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q.phase <= ifps_pkg::PhIdle;
      step_q.bits  <= '0;
      wait_q       <= '0;
      shift_q      <= '0;
      op_q         <= '0;
      addr_q       <= '0;
      read_q       <= '0;
    end else if (accept_i) begin
      step_q  <= step_d;
      wait_q  <= wait_d;
      shift_q <= shift_d;
      op_q    <= op_cur;
      addr_q  <= addr_cur;
      read_q  <= read_d;
    end
  end

endmodule

// ===== src/ifps_obuf.sv =====
`timescale 1ns / 1ps

module ifps_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ifps_pkg::res_t   res_i,
  output logic             ready_o,
  ifps_res_if.source       res_o
);

  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  ifps_pkg::res_t  out_q, out_d, skid_q, skid_d;
  logic            pop;

  assign ready_o = !skid_valid_q;
  assign pop     = out_valid_q && res_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_valid_d = 1'b1;
        skid_d       = res_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = push_i;
      if (push_i) begin
        out_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.clock_pin  = out_q.clock_pin;
  assign res_o.data_pin   = out_q.data_pin;
  assign res_o.data_drive = out_q.data_drive;
  assign res_o.reset_pin  = out_q.reset_pin;
  assign res_o.busy_res   = out_q.busy_res;
  assign res_o.done_res   = out_q.done_res;
  assign res_o.read_word  = out_q.read_word;

endmodule

// ===== src/isp_flash_pin_sequencer.sv =====
`timescale 1ns / 1ps
// Each result word is registered in the output buffer, or in its skid entry while the result side stalls.
// Throughput: one tick word per cycle, sustained, while the result side keeps up;
// a two-entry output buffer keeps the input open until its skid entry fills during a result stall.
// Reset: rst_ni is asynchronous and active low; it returns the sequencer to idle,
// clears the read word and loads the timing registers with their defaults.

module isp_flash_pin_sequencer #(
  parameter int unsigned ADDRESS_BITS = ifps_pkg::AddressBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ifps_item_if.sink   item_i,
  ifps_cfg_if.sink    cfg_i,
  ifps_res_if.source  res_o
);

  // Each tick word is one microsecond of the programming sequence. The core
  // holds the phase, the bit or pulse count and the tick countdown of the
  // current segment, and works out the pin levels for the tick and the next
  // state in one pass of logic. State only moves on an accepted word, so a
  // stalled input simply freezes the pin sequence.

  ifps_pkg::cfg_t   cfg;
  ifps_pkg::item_t  item;
  ifps_pkg::res_t   res;
  logic             in_ready;
  logic             accept;

  // Timing registers written through the configuration channel.
  ifps_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign item.start_req    = item_i.start_req;
  assign item.operation    = item_i.operation;
  assign item.word_address = item_i.word_address;
  assign item.write_word   = item_i.write_word;
  assign item.sda_sample   = item_i.sda_sample;

  assign item_i.ready = in_ready;
  assign accept       = item_i.valid && in_ready;

  // Phase sequencer: mode code, address frame, data or read shift, erase and
  // program pulses, exit pulses and the write recovery time.
  ifps_core #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Result register with a skid entry behind it; the input is ready whenever
  // the skid entry is free.
  ifps_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .ready_o (in_ready),
    .res_o   (res_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the ISP flash pin sequencer. Every tick word sent in
// runs through an in-bench copy of the sequencer's behavior, which queues the
// pin levels it expects. A checker then compares each result word that leaves
// the block, field by field, with the oldest queued expectation.
module tb_top;
  import ifps_pkg::*;

  // Operation code that the block must ignore.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  // Run limit in ns. It covers the slowest correct run with every word meeting
  // the longest gap and the longest result stall, taken several times over.
  localparam int unsigned RunLimitNs = 20_000_000;

  // How a tick word fills in the level seen on SDA.
  typedef enum logic [1:0] {
    SdaRandom,
    SdaLow,
    SdaHigh
  } sda_pat_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ifps_item_if item_if ();
  ifps_cfg_if  cfg_if ();
  ifps_res_if  res_if ();

  isp_flash_pin_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Pin levels still owed by the block, oldest first.
  res_t pin_levels_q[$];

  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;

  // Set for the last stretch of the run: no gaps on either side.
  bit quiet = 1'b0;

  // Shadow copy of the timing registers.
  logic [WaitW-1:0]  erase_wait_us;
  logic [ShortW-1:0] erase_settle_us;
  logic [ShortW-1:0] write_recover_us;

  // Shadow copy of the sequencer state.
  phase_e            seq_phase;
  logic [CountW-1:0] seq_bits;
  logic [WaitW-1:0]  seq_wait;
  logic [WordW-1:0]  seq_shift;
  logic [OpW-1:0]    seq_op;
  logic [AddrW-1:0]  seq_addr;
  logic [WordW-1:0]  seq_read_word;

  // Mode code clocked out on RESETB for the operation in flight.
  function automatic logic [WordW-1:0] mode_word();
    case (seq_op)
      OpErase: return WordW'(ModeErase);
      OpRead:  return WordW'(ModeRead);
      default: return WordW'(ModeWrite);
    endcase
  endfunction

  // The bit of a frame being sent now; frames go out MSB first.
  function automatic logic frame_bit(logic [WordW-1:0] frame);
    return frame[5'(seq_bits - 6'd1)];
  endfunction

  // Length of the segment the sequencer has just entered, in ticks.
  function automatic logic [WaitW-1:0] segment_ticks();
    int unsigned step;
    step = (6 - int'(seq_bits)) % 6;
    case (seq_phase)
      PhE1s, PhE2s:               return LenEraseSet;
      PhEw:                       return erase_wait_us;
      PhEs:                       return WaitW'(erase_settle_us);
      PhRw:                       return LenReadWait;
      PhRlh, PhRll:               return LenLoad;
      PhRxl, PhRxh, PhWfh, PhWfl: return LenOne;
      PhWpl, PhWph: begin
        // The third and fourth program steps are held longer than the rest.
        if (step == 2) return 16'd6;
        if (step == 3) return 16'd12;
        return LenBase;
      end
      PhRec:                      return WaitW'(write_recover_us);
      PhIdle:                     return '0;
      default:                    return LenBase;
    endcase
  endfunction

  // Moves the shadow sequencer on to its next segment.
  function automatic void next_segment();
    case (seq_phase)
      PhMs: seq_phase = PhMh;
      PhMh: seq_phase = PhMl;
      PhMl: begin
        if (seq_bits > 1) begin
          seq_bits--;
          seq_phase = PhMs;
        end else if (seq_op == OpErase) begin
          seq_phase = PhE1s;
        end else begin
          seq_bits = FrameBits;
          seq_phase = PhAs;
        end
      end
      PhAs: seq_phase = PhAh;
      PhAh: seq_phase = PhAl;
      PhAl: begin
        if (seq_bits > 1) begin
          seq_bits--;
          seq_phase = PhAs;
        end else if (seq_op == OpRead) begin
          seq_phase = PhRw;
        end else begin
          seq_bits = DataBits;
          seq_phase = PhDs;
        end
      end
      PhDs: seq_phase = PhDh;
      PhDh: seq_phase = PhDl;
      PhDl: begin
        if (seq_bits > 1) begin
          seq_bits--;
          seq_phase = PhDs;
        end else begin
          seq_bits = ProgSteps;
          seq_phase = PhWpl;
        end
      end
      PhE4l: seq_phase = PhXs;
      PhRw: begin
        seq_bits = LoadPulses;
        seq_phase = PhRlh;
      end
      PhRlh: seq_phase = PhRll;
      PhRll: begin
        if (seq_bits > 1) begin
          seq_bits--;
          seq_phase = PhRlh;
        end else begin
          seq_bits = DataBits;
          seq_phase = PhRxl;
        end
      end
      PhRxl: seq_phase = PhRxh;
      PhRxh: begin
        if (seq_bits > 1) begin
          seq_bits--;
          seq_phase = PhRxl;
        end else begin
          seq_phase = PhXs;
        end
      end
      PhWpl: seq_phase = PhWph;
      PhWph: begin
        if (seq_bits > 1) begin
          seq_bits--;
          seq_phase = PhWpl;
        end else begin
          seq_phase = PhWfh;
        end
      end
      PhWfh: seq_phase = PhWfl;
      PhWfl: seq_phase = PhXs;
      PhXs: begin
        seq_bits = ExitPulses;
        seq_phase = PhXh;
      end
      PhXh: seq_phase = PhXl;
      PhXl: begin
        if (seq_bits > 1) begin
          seq_bits--;
          seq_phase = PhXh;
        end else begin
          seq_phase = (seq_op == OpWrite) ? PhRec : PhIdle;
        end
      end
      PhRec: seq_phase = PhIdle;
      default: begin
        // The erase pulses run straight through from first setup to last low.
        if (seq_phase >= PhE1s && seq_phase < PhE4l) seq_phase = phase_e'(seq_phase + 6'd1);
        else seq_phase = PhIdle;
      end
    endcase
  endfunction

  // Takes one tick word and returns the pin levels of that tick.
  function automatic res_t pin_tick(item_t it);
    res_t pins;
    pins = '0;
    // A start is taken only while idle, and only for a known operation. The tick
    // that takes it is already the first tick of the sequence.
    if (seq_phase == PhIdle && it.start_req && it.operation != OpUnused) begin
      seq_op = it.operation;
      seq_addr = it.word_address;
      seq_shift = (it.operation == OpWrite) ? it.write_word : '0;
      seq_bits = ModeBits;
      seq_phase = PhMs;
      seq_wait = segment_ticks();
    end
    if (seq_phase != PhIdle) begin
      pins.busy_res = 1'b1;
      pins.data_drive = 1'b1;
      case (seq_phase)
        PhMh, PhAh, PhDh, PhE1h, PhE2h, PhE3h, PhE4h, PhRlh, PhRxh, PhWph, PhWfh, PhXh:
          pins.clock_pin = 1'b1;
        // A read leaves SCL high through the setup ahead of the exit pulses.
        PhXs: pins.clock_pin = (seq_op == OpRead);
        default: ;
      endcase
      if (seq_phase == PhMs || seq_phase == PhMh || seq_phase == PhMl) begin
        pins.reset_pin = frame_bit(mode_word());
        pins.data_pin = 1'b1;
      end else if (seq_phase == PhAs || seq_phase == PhAh || seq_phase == PhAl) begin
        pins.data_pin = frame_bit(WordW'({seq_addr, 1'b0}));
      end else if (seq_phase == PhDs || seq_phase == PhDh || seq_phase == PhDl) begin
        pins.data_pin = frame_bit(seq_shift);
      end else if ((seq_phase >= PhE1s && seq_phase <= PhE4l) ||
                   (seq_phase >= PhWpl && seq_phase <= PhWfl)) begin
        pins.data_pin = 1'b1;
      end else if (seq_phase == PhRxl || seq_phase == PhRxh) begin
        // SDA is released while the flash shifts its word out; the level is 0.
        pins.data_drive = 1'b0;
      end
      // Read bits are taken while SCL is high; the word shows on the last one.
      if (seq_phase == PhRxh) begin
        seq_shift = {seq_shift[WordW-2:0], it.sda_sample};
        if (seq_bits == 1) seq_read_word = seq_shift;
      end
      if (seq_wait > 0) seq_wait--;
      if (seq_wait == 0) begin
        // Segments of zero length, such as a zero recovery time, are skipped.
        do begin
          next_segment();
          seq_wait = segment_ticks();
        end while (seq_wait == 0 && seq_phase != PhIdle);
        if (seq_phase == PhIdle) pins.done_res = 1'b1;
      end
    end
    pins.read_word = seq_read_word;
    return pins;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // A tick word with random content; SDA follows the requested pattern.
  function automatic item_t random_tick(sda_pat_e sda);
    item_t it;
    it.start_req = 1'($urandom_range(0, 1));
    it.operation = OpW'($urandom_range(OpErase, OpUnused));
    it.word_address = AddrW'($urandom);
    it.write_word = $urandom;
    case (sda)
      SdaLow:  it.sda_sample = 1'b0;
      SdaHigh: it.sda_sample = 1'b1;
      default: it.sda_sample = 1'($urandom_range(0, 1));
    endcase
    return it;
  endfunction

  // An idle tick that must not start anything: no request, or the unused code.
  function automatic item_t stray_tick();
    item_t it;
    it = random_tick(SdaRandom);
    if ($urandom_range(0, 1) == 0) it.start_req = 1'b0;
    else it.operation = OpUnused;
    return it;
  endfunction

  // Sends one tick word, now and then after a random gap, and queues the pin
  // levels expected for it once the block has taken it.
  task automatic send_tick(input item_t it);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 19) == 0) ? $urandom_range(1, 17) : 0;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.start_req <= it.start_req;
    item_if.operation <= it.operation;
    item_if.word_address <= it.word_address;
    item_if.write_word <= it.write_word;
    item_if.sda_sample <= it.sda_sample;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    pin_levels_q.push_back(pin_tick(it));
  endtask

  // Holds the sender until every queued result word has come out.
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pin_levels_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      CfgEraseWait:    erase_wait_us = value;
      CfgEraseSettle:  erase_settle_us = value[ShortW-1:0];
      CfgWriteRecover: write_recover_us = value[ShortW-1:0];
      default: ;
    endcase
  endtask

  // Loads all three timing registers; only called with the block idle.
  task automatic set_timing(input logic [WaitW-1:0] wait_us, input logic [ShortW-1:0] settle_us,
                            input logic [ShortW-1:0] recover_us);
    write_reg(CfgEraseWait, wait_us);
    write_reg(CfgEraseSettle, CfgDataW'(settle_us));
    write_reg(CfgWriteRecover, CfgDataW'(recover_us));
    cfg_if.valid <= 1'b0;
  endtask

  // Starts one operation on the first tick and keeps ticking until the shadow
  // sequencer is idle again. The busy ticks carry random requests, which must
  // be ignored. A nonzero hold_at pauses the sender at that tick until all
  // results are in.
  task automatic run_operation(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                               input logic [WordW-1:0] wdata, input sda_pat_e sda,
                               input int unsigned hold_at);
    item_t it;
    int unsigned n;
    it = random_tick(sda);
    it.start_req = 1'b1;
    it.operation = op;
    it.word_address = addr;
    it.write_word = wdata;
    send_tick(it);
    n = 0;
    while (seq_phase != PhIdle) begin
      send_tick(random_tick(sda));
      n++;
      if (n == hold_at) wait_drained();
    end
  endtask

  // Idle ticks at field extremes, then a request with the unused code.
  task automatic test_idle_ticks();
    item_t it;
    it.start_req = 1'b0;
    it.operation = OpUnused;
    it.word_address = '1;
    it.write_word = '1;
    it.sda_sample = 1'b1;
    send_tick(it);
    it = '0;
    send_tick(it);
    it.start_req = 1'b1;
    it.operation = OpUnused;
    send_tick(it);
  endtask

  // Short timings: a zero wait after the second erase pulse is skipped outright in this erase,
  // and the zero recovery time set here is skipped outright by the later write.
  task automatic test_erase_short();
    wait_drained();
    set_timing(16'd0, 10'd1, 10'd0);
    run_operation(OpErase, AddrW'($urandom), $urandom, SdaHigh, 0);
  endtask

  // Read at the top address. The sender pauses while the flash shifts its
  // word out.
  task automatic test_read_word();
    repeat ($urandom_range(0, 3)) send_tick(stray_tick());
    run_operation(OpRead, '1, '0, SdaRandom, 480);
  endtask

  // Write with no gaps or stalls on either side.
  task automatic test_write_word();
    repeat ($urandom_range(0, 3)) send_tick(stray_tick());
    quiet = 1'b1;
    run_operation(OpWrite, AddrW'($urandom), $urandom, SdaLow, 0);
  endtask

  // Result side: ready drops in random bursts until the quiet stretch.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && !quiet && $urandom_range(0, 19) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compares every result word taken from the block with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pin_levels_q.size() == 0) begin
        flag_mismatch($sformatf("result word %0d arrived with nothing expected", result_count));
      end else begin
        want = pin_levels_q.pop_front();
        if (res_if.clock_pin !== want.clock_pin)
          flag_mismatch($sformatf("word %0d clock_pin %b, want %b", result_count,
                                  res_if.clock_pin, want.clock_pin));
        if (res_if.data_pin !== want.data_pin)
          flag_mismatch($sformatf("word %0d data_pin %b, want %b", result_count,
                                  res_if.data_pin, want.data_pin));
        if (res_if.data_drive !== want.data_drive)
          flag_mismatch($sformatf("word %0d data_drive %b, want %b", result_count,
                                  res_if.data_drive, want.data_drive));
        if (res_if.reset_pin !== want.reset_pin)
          flag_mismatch($sformatf("word %0d reset_pin %b, want %b", result_count,
                                  res_if.reset_pin, want.reset_pin));
        if (res_if.busy_res !== want.busy_res)
          flag_mismatch($sformatf("word %0d busy_res %b, want %b", result_count,
                                  res_if.busy_res, want.busy_res));
        if (res_if.done_res !== want.done_res)
          flag_mismatch($sformatf("word %0d done_res %b, want %b", result_count,
                                  res_if.done_res, want.done_res));
        if (res_if.read_word !== want.read_word)
          flag_mismatch($sformatf("word %0d read_word %h, want %h", result_count,
                                  res_if.read_word, want.read_word));
      end
      result_count++;
    end
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(RunLimitNs);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    // Every input starts at a known level before reset is released.
    rst_ni <= 1'b0;
    item_if.valid <= 1'b0;
    item_if.start_req <= 1'b0;
    item_if.operation <= OpErase;
    item_if.word_address <= '0;
    item_if.write_word <= '0;
    item_if.sda_sample <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CfgEraseWait;
    cfg_if.data <= '0;

    erase_wait_us = EraseWaitRst;
    erase_settle_us = EraseSettleRst;
    write_recover_us = WriteRecoverRst;
    seq_phase = PhIdle;
    seq_bits = '0;
    seq_wait = '0;
    seq_shift = '0;
    seq_op = OpErase;
    seq_addr = '0;
    seq_read_word = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_erase_short();
    test_read_word();
    test_write_word();

    // Let the last result words drain and the pipeline settle.
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ifps_pkg.sv
src/ifps_if.sv
src/ifps_regs.sv
src/ifps_core.sv
src/ifps_obuf.sv
src/isp_flash_pin_sequencer.sv
tb/tb_top.sv
